// ===== hdl/pwl_pkg.sv =====
`timescale 1ns / 1ps
package pwl_pkg;

  localparam int MAX_POINTS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic CMD_EVAL = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [4:0] NUM_POINTS_RST = 5'd2;

  typedef struct packed {
    logic               command;
    logic [3:0]         entry_index;
    logic signed [31:0] x_value;
    logic signed [31:0] slope_value;
    logic signed [31:0] intercept_value;
  } pwl_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               out_of_range;
    logic               saturated;
  } pwl_out_t;

  // classified evaluation waiting for the datapath
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic               oor;
  } pwl_job_t;

endpackage

// ===== hdl/pwl_front.sv =====
`timescale 1ns / 1ps
module pwl_front #(
  parameter int MAX_POINTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  logic              push,
  input  pwl_pkg::pwl_in_t  in_item,
  input  logic              q_full,
  output logic              q_push,
  output pwl_pkg::pwl_job_t q_job
);
  import pwl_pkg::*;

  // only sixteen entries are addressable by a load
  localparam int DEPTH = (MAX_POINTS < 16) ? MAX_POINTS : 16;
  localparam int IW    = $clog2(DEPTH);

  logic [4:0]         num_points_r;
  logic signed [31:0] bp_r    [DEPTH];
  logic signed [31:0] slope_r [DEPTH];
  logic signed [31:0] icpt_r  [DEPTH];

  logic               accept;
  logic               do_load;
  logic [6:0]         n_use;
  logic [IW-1:0]      seg;
  logic               found;
  logic               below;

  assign accept  = push && !q_full;
  assign do_load = accept && (in_item.command == CMD_LOAD) &&
                   (32'(in_item.entry_index) < MAX_POINTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= NUM_POINTS_RST;
    end else if (cfg_we) begin
      num_points_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      bp_r[in_item.entry_index[IW-1:0]]    <= in_item.x_value;
      slope_r[in_item.entry_index[IW-1:0]] <= in_item.slope_value;
      icpt_r[in_item.entry_index[IW-1:0]]  <= in_item.intercept_value;
    end
  end

  always_comb begin
    if ({2'b00, num_points_r} < 7'd2) begin
      n_use = 7'd2;
    end else if ({2'b00, num_points_r} > 7'(MAX_POINTS)) begin
      n_use = 7'(MAX_POINTS);
    end else begin
      n_use = {2'b00, num_points_r};
    end
  end

  // first breakpoint at or above x wins, so scan from the top down
  always_comb begin
    seg   = '0;
    found = 1'b0;
    for (int k = DEPTH - 1; k >= 1; k--) begin
      if ((7'(k) < n_use) && (in_item.x_value <= bp_r[k])) begin
        seg   = IW'(k - 1);
        found = 1'b1;
      end
    end
  end

  assign below = in_item.x_value < bp_r[0];

  assign q_push          = accept && (in_item.command == CMD_EVAL);
  assign q_job.x         = in_item.x_value;
  assign q_job.slope     = slope_r[seg];
  assign q_job.intercept = icpt_r[seg];
  assign q_job.oor       = below || !found;

endmodule

// ===== hdl/pwl_fifo.sv =====
`timescale 1ns / 1ps
module pwl_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pwl_pkg::pwl_job_t wdata,
  output logic              full,
  input  logic              pop,
  output pwl_pkg::pwl_job_t rdata,
  output logic              empty
);
  import pwl_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  pwl_job_t      mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = count_r == CW'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== hdl/pwl_back.sv =====
`timescale 1ns / 1ps
module pwl_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  pwl_pkg::pwl_job_t q_job,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output pwl_pkg::pwl_out_t out_item
);
  import pwl_pkg::*;

  logic               s1_valid_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] icpt_r;
  logic               oor_r;

  logic               s2_valid_r;
  pwl_out_t           out_r, out_nxt;

  logic               s1_ready, s2_ready;
  logic signed [63:0] shifted;
  logic signed [64:0] sum;
  logic               ovf;

  assign s2_ready = !s2_valid_r || pop;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign q_pop    = !q_empty && s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_r <= 64'(q_job.slope) * 64'(q_job.x);
      icpt_r <= q_job.intercept;
      oor_r  <= q_job.oor;
    end
  end

  // arithmetic shift gives floor rounding
  assign shifted = prod_r >>> FRACTION_BITS;
  assign sum     = 65'(shifted) + 65'(icpt_r);
  assign ovf     = !((sum[64:31] == '0) || (sum[64:31] == '1));

  always_comb begin
    out_nxt.out_of_range = oor_r;
    out_nxt.saturated    = 1'b0;
    out_nxt.result_value = sum[31:0];
    if (oor_r) begin
      out_nxt.result_value = '0;
    end else if (ovf) begin
      out_nxt.saturated    = 1'b1;
      out_nxt.result_value = sum[64] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign empty    = !s2_valid_r;
  assign out_item = out_r;

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && out_r.out_of_range) |-> (out_r.result_value == '0 && !out_r.saturated))
    else $error("out-of-range item carries a value");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !pop) |=> (s2_valid_r && $stable(out_r)))
    else $error("waiting result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !s2_valid_r))
    else $error("datapath not empty after reset");

endmodule

// ===== hdl/piecewise_linear_evaluator_top.sv =====
`timescale 1ns / 1ps
// Piecewise linear function evaluator, signed Q16.16.
// Input channel: push / full with in_item. A load item (command set) writes
// breakpoint, slope and intercept of entry entry_index and gives no result.
// An evaluate item gives one result: slope*x + intercept of the segment that
// holds x, floored and saturated to 32 bits, or the out-of-range flag.
// Result channel: empty / pop with out_item; the oldest result is shown while
// empty is low. Configuration: cfg_we writes cfg_wdata to the point count.
// An evaluate item is classified into a four-deep queue, then multiplied in the
// multiply register and added and clipped into the output register. Throughput
// is one item per cycle while the receiver keeps popping, set by the single
// comparator bank in the front and the one-stage multiplier in the back.
// A stalled receiver fills the output register, the multiply stage and then
// the queue; full rises once the queue holds four items, while loads also
// wait behind it.
// Reset empties queue and datapath and sets the point count to two; the table
// contents are kept and must be loaded before use.
module piecewise_linear_evaluator_top #(
  parameter int MAX_POINTS    = pwl_pkg::MAX_POINTS_DEF,
  parameter int FRACTION_BITS = pwl_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  pwl_pkg::pwl_in_t  in_item,
  output logic              empty,
  input  logic              pop,
  output pwl_pkg::pwl_out_t out_item,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata
);
  import pwl_pkg::*;

  logic     q_push, q_pop, q_full, q_empty;
  pwl_job_t q_wjob, q_rjob;

  assign full = q_full;

  pwl_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_wjob)
  );

  pwl_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wjob),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rjob),
    .empty (q_empty)
  );

  pwl_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (q_rjob),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// ===== test/piecewise_linear_evaluator_checker.sv =====
`timescale 1ns / 1ps
module piecewise_linear_evaluator_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              full,
  input  pwl_pkg::pwl_in_t  in_item,
  input  logic              empty,
  input  logic              pop,
  input  pwl_pkg::pwl_out_t out_item,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  output int                mismatches,
  output int                outstanding
);
  import pwl_pkg::*;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic signed [31:0] knot_x     [MAX_POINTS_DEF];
  logic signed [31:0] knot_slope [MAX_POINTS_DEF];
  logic signed [31:0] knot_icpt  [MAX_POINTS_DEF];
  logic [4:0]         point_count;
  pwl_out_t           awaited [$];
  int                 err_total = 0;

  // value of the segment holding x, or the out-of-range answer
  function automatic pwl_out_t evaluate_at(input logic signed [31:0] x);
    pwl_out_t r;
    int       used;
    int       seg;
    int       k;
    longint   prod;
    longint   y;
    used = point_count;
    if (used < 2) used = 2;
    if (used > MAX_POINTS_DEF) used = MAX_POINTS_DEF;
    seg = -1;
    r = '0;
    r.out_of_range = 1'b1;
    if (x >= knot_x[0]) begin
      for (k = 1; k < used; k++) begin
        if (seg < 0 && x <= knot_x[k]) seg = k - 1;
      end
    end
    if (seg >= 0) begin
      prod = longint'(knot_slope[seg]) * longint'(x);
      // arithmetic shift of the exact product floors towards minus infinity
      y = (prod >>> FRACTION_BITS_DEF) + longint'(knot_icpt[seg]);
      r.out_of_range = 1'b0;
      if (y > SAT_HI) begin
        y = SAT_HI;
        r.saturated = 1'b1;
      end else if (y < SAT_LO) begin
        y = SAT_LO;
        r.saturated = 1'b1;
      end
      r.result_value = y[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pwl_out_t want;
    if (!rst_n) begin
      point_count = NUM_POINTS_RST;
      awaited.delete();
    end else begin
      if (cfg_we) point_count = cfg_wdata;
      if (push && !full) begin
        if (in_item.command == CMD_LOAD) begin
          knot_x[in_item.entry_index]     = in_item.x_value;
          knot_slope[in_item.entry_index] = in_item.slope_value;
          knot_icpt[in_item.entry_index]  = in_item.intercept_value;
        end else begin
          awaited.push_back(evaluate_at(in_item.x_value));
        end
      end
      if (pop && !empty) begin
        if (awaited.size() == 0) begin
          $display("%t unexpected item: expected none, got %0d oor %b sat %b", $time,
                   out_item.result_value, out_item.out_of_range, out_item.saturated);
          err_total++;
        end else begin
          want = awaited.pop_front();
          if (out_item.result_value !== want.result_value) begin
            $display("%t result_value: expected %0d, got %0d", $time,
                     want.result_value, out_item.result_value);
            err_total++;
          end
          if (out_item.out_of_range !== want.out_of_range) begin
            $display("%t out_of_range: expected %b, got %b", $time,
                     want.out_of_range, out_item.out_of_range);
            err_total++;
          end
          if (out_item.saturated !== want.saturated) begin
            $display("%t saturated: expected %b, got %b", $time,
                     want.saturated, out_item.saturated);
            err_total++;
          end
        end
      end
    end
    mismatches  <= err_total;
    outstanding <= awaited.size();
  end

endmodule

// ===== test/piecewise_linear_evaluator_top_test.sv =====
`timescale 1ns / 1ps
module piecewise_linear_evaluator_top_test;
  import pwl_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_CYCLES     = 80;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       push;
  logic       full;
  pwl_in_t    in_item;
  logic       empty;
  logic       pop;
  pwl_out_t   out_item;
  logic       cfg_we;
  logic [4:0] cfg_wdata;
  int         mismatches;
  int         outstanding;
  int         sent_total = 0;
  int         idle_cycles = 0;

  // breakpoints as last loaded, used to aim arguments at the segments
  logic signed [31:0] knots [MAX_POINTS_DEF];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  piecewise_linear_evaluator_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  piecewise_linear_evaluator_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic offer(input pwl_in_t it);
    bit calm;
    calm = (sent_total >= 350 && sent_total < 500);
    while (!calm && $urandom_range(99) < 32) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    sent_total++;
  endtask

  task automatic load_knot(input logic [3:0] idx, input logic signed [31:0] bx,
                           input logic signed [31:0] a, input logic signed [31:0] b);
    pwl_in_t it;
    it.command         = CMD_LOAD;
    it.entry_index     = idx;
    it.x_value         = bx;
    it.slope_value     = a;
    it.intercept_value = b;
    knots[idx] = bx;
    offer(it);
  endtask

  task automatic eval_at(input logic signed [31:0] x);
    pwl_in_t it;
    it.command         = CMD_EVAL;
    it.entry_index     = 4'($urandom);
    it.x_value         = x;
    it.slope_value     = $urandom;
    it.intercept_value = $urandom;
    offer(it);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // loads give no result and may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] draw_coefficient();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom) >>> $urandom_range(8, 24);
      2: begin
        case ($urandom_range(3))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $urandom_range(262143) - 131072;
    endcase
  endfunction

  initial begin : receiver
    int popped;
    bit held;
    bit calm;
    popped = 0;
    held   = 1'b0;
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) popped++;
      calm = (popped >= 300 && popped < 450);
      if (!held && popped >= 150) begin
        // long hold-off so the queue fills and full backs up the sender
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  initial begin : stimulus
    logic [4:0]         phase_points [$];
    int                 spread [$];
    int                 order [MAX_POINTS_DEF];
    int                 used;
    int                 k;
    int                 j;
    int                 tmp;
    int                 pick;
    longint             lo;
    longint             hi;
    logic signed [31:0] x;

    rst_n     <= 1'b0;
    push      <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset point count of two: one segment across the whole range
    load_knot(0, Q_MIN, Q_MAX, Q_MAX);
    load_knot(1, Q_MAX, 0, 0);
    load_knot(15, Q_MIN, Q_MAX, Q_MIN);
    eval_at(Q_MIN);
    eval_at(Q_MAX);
    eval_at(0);
    eval_at(-1);
    eval_at(1);
    // narrow segment: below, above and exactly on both ends
    load_knot(0, -32'sh10000, Q_MIN, Q_MIN);
    load_knot(1, 32'sh10000, 0, 0);
    eval_at(-32'sh10001);
    eval_at(32'sh10001);
    eval_at(-32'sh10000);
    eval_at(32'sh10000);
    eval_at(32'sh8000);

    phase_points = '{5'd16, 5'd31, 5'd0, 5'd17, 5'd1, 5'd5, 5'd9, 5'd2};
    phase_points.push_back(5'($urandom_range(31)));

    foreach (phase_points[p]) begin
      wait_drained();
      cfg_we    <= 1'b1;
      cfg_wdata <= phase_points[p];
      @(posedge clk);
      cfg_we <= 1'b0;

      used = phase_points[p];
      if (used < 2) used = 2;
      if (used > MAX_POINTS_DEF) used = MAX_POINTS_DEF;

      // fresh table, ascending except in one phase, loaded in shuffled order
      spread.delete();
      for (k = 0; k < MAX_POINTS_DEF; k++) begin
        spread.push_back($signed($urandom) >>> $urandom_range(0, 24));
        order[k] = k;
      end
      if (p != 3) spread.sort();
      for (k = MAX_POINTS_DEF - 1; k > 0; k--) begin
        j = $urandom_range(k);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      for (k = 0; k < MAX_POINTS_DEF; k++) begin
        load_knot(4'(order[k]), spread[order[k]], draw_coefficient(), draw_coefficient());
      end

      for (k = 0; k < ITEMS_PER_PHASE - MAX_POINTS_DEF; k++) begin
        pick = $urandom_range(99);
        lo = longint'(knots[0]);
        hi = longint'(knots[used - 1]);
        if (pick < 6) begin
          load_knot(4'($urandom_range(15)), $signed($urandom) >>> $urandom_range(0, 24),
                    draw_coefficient(), draw_coefficient());
        end else begin
          if (pick < 55 && hi >= lo) begin
            x = 32'(lo + (longint'($urandom) % (hi - lo + 1)));
          end else if (pick < 70) begin
            x = knots[($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(used - 1)];
          end else if (pick < 80) begin
            x = knots[$urandom_range(used - 1)] + ($urandom_range(1) ? 1 : -1);
          end else if (pick < 92) begin
            x = $urandom;
          end else begin
            case ($urandom_range(3))
              0: x = Q_MIN;
              1: x = Q_MAX;
              2: x = 0;
              default: x = -1;
            endcase
          end
          eval_at(x);
        end
      end
    end

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
